// ===== hdl/lspt_pkg.sv =====
// Shared types and fixed constants for the line segment pixel trace block.
// Holds the grid geometry and the job word passed from the setup front end to the cell stepper.
// No dependencies.
package lspt_pkg;

    // Grid is 32 cells a side; coordinates carry 11 fraction bits (Q5.11).
    localparam int GRID_SIZE       = 32;
    localparam int COORD_FRAC_BITS = 11;

    typedef struct packed {
        logic [15:0] xs;
        logic [15:0] ys;
        logic [15:0] xe;
        logic [15:0] ye;
        logic [15:0] adx;
        logic [15:0] ady;
        logic        xup;
        logic        yup;
        logic [16:0] len;
    } lspt_job_t;

endpackage

// ===== hdl/line_segment_pixel_trace.sv =====
// Top level of the line segment pixel trace block.
// Wires setup front end, job queue and cell stepper; depends on lspt_pkg.
//
//  channel | valid     | stall     | word fields
//  in      | valid     | in_stall  | start_x start_y end_x end_y
//  out     | out_valid | stall     | cell_column cell_row path_distance last_cell
//
// Setup: accept the word, 17 square-root steps of dx^2+dy^2, then hand off; the input
// stalls after each accepted word until the hand-off (longer while the queue is full).
// Stepper: each grid-line crossing takes pick, multiply, 17 divide steps and emit; a job
// also takes a pickup step and a step for the final cell.
// The front end sets up the next segment while the stepper works; the queue holds two.
// Reset clears only control state; a stalled output word holds and stops the stepper at its next emit.
module line_segment_pixel_trace (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        in_stall,
    input  logic [15:0] start_x,
    input  logic [15:0] start_y,
    input  logic [15:0] end_x,
    input  logic [15:0] end_y,
    output logic        out_valid,
    input  logic        stall,
    output logic [4:0]  cell_column,
    output logic [4:0]  cell_row,
    output logic [16:0] path_distance,
    output logic        last_cell
);
    import lspt_pkg::*;

    lspt_job_t f_job, q_job;
    logic      f_valid, f_stall, q_valid, q_stall;

    lspt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
    );

    lspt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
        .rd_valid(q_valid), .rd_stall(q_stall), .rd_job(q_job)
    );

    lspt_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
        .out_valid(out_valid), .out_stall(stall), .cell_column(cell_column),
        .cell_row(cell_row), .path_distance(path_distance), .last_cell(last_cell)
    );

endmodule

// ===== hdl/lspt_front.sv =====
// Setup front end: clamps coordinates, takes |dx|, |dy| and the segment length.
// The length comes from a restoring square root, one result bit per cycle.
// Depends on lspt_pkg.
module lspt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        start_x,
    input  logic [15:0]        start_y,
    input  logic [15:0]        end_x,
    input  logic [15:0]        end_y,
    output logic               job_valid,
    input  logic               job_stall,
    output lspt_pkg::lspt_job_t job
);
    import lspt_pkg::*;

    localparam logic [16:0] LIM = 17'((GRID_SIZE << COORD_FRAC_BITS) - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROOT = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    lspt_job_t   job_reg;
    logic [32:0] rem_reg;
    logic [16:0] root_reg;
    logic [4:0]  cnt_reg;

    function automatic logic [15:0] clampc(input logic [15:0] v);
        return ({1'b0, v} > LIM) ? LIM[15:0] : v;
    endfunction

    logic [15:0] cxs, cys, cxe, cye, adx, ady;
    logic [32:0] sumsq;

    always_comb
    begin
        cxs = clampc(start_x);
        cys = clampc(start_y);
        cxe = clampc(end_x);
        cye = clampc(end_y);
        adx = (cxe >= cxs) ? cxe - cxs : cxs - cxe;
        ady = (cye >= cys) ? cye - cys : cys - cye;
        sumsq = 33'(32'(adx) * 32'(adx)) + 33'(32'(ady) * 32'(ady));
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_ROOT;
            S_ROOT: if (cnt_reg == 5'd0) state_next = S_DONE;
            S_DONE: if (!job_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Restoring square root: 17 result bits, one per cycle, from the top pair down.
    logic [33:0] part_reg;
    logic [33:0] part_sh;
    logic [33:0] sub_try;
    logic [1:0]  pair;
    always_comb
    begin
        pair    = 2'((rem_reg >> (2 * cnt_reg)) & 33'd3);
        part_sh = {part_reg[31:0], pair};
        sub_try = {15'd0, root_reg, 2'b01};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg.xs  <= cxs;
                job_reg.ys  <= cys;
                job_reg.xe  <= cxe;
                job_reg.ye  <= cye;
                job_reg.adx <= adx;
                job_reg.ady <= ady;
                job_reg.xup <= cxe >= cxs;
                job_reg.yup <= cye >= cys;
                rem_reg     <= sumsq;
                root_reg    <= '0;
                part_reg    <= '0;
                cnt_reg     <= 5'd16;
            end
            S_ROOT:
            begin
                if (part_sh >= sub_try)
                begin
                    part_reg <= part_sh - sub_try;
                    root_reg <= {root_reg[15:0], 1'b1};
                end
                else
                begin
                    part_reg <= part_sh;
                    root_reg <= {root_reg[15:0], 1'b0};
                end
                if (cnt_reg == 5'd0)
                    job_reg.len <= (part_sh >= sub_try) ? {root_reg[15:0], 1'b1}
                                                        : {root_reg[15:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
            end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign job_valid = (state_reg == S_DONE);
    assign job       = job_reg;

endmodule

// ===== hdl/lspt_queue.sv =====
// Two-entry job queue between setup and stepping so each side stalls on its own.
// Depends on lspt_pkg.
module lspt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_stall,
    input  lspt_pkg::lspt_job_t wr_job,
    output logic               rd_valid,
    input  logic               rd_stall,
    output lspt_pkg::lspt_job_t rd_job
);
    import lspt_pkg::*;

    lspt_job_t mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      wr_go, rd_go;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr_go    = wr_valid && !wr_stall;
    assign rd_go    = rd_valid && !rd_stall;
    assign rd_job   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_go) wp_reg <= !wp_reg;
            if (rd_go) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_go} - {1'b0, rd_go};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_go) mem_reg[wp_reg] <= wr_job;
    end

endmodule

// ===== hdl/lspt_back.sv =====
// Cell stepper: walks grid-line crossings in distance order and emits one cell a word.
// A crossing distance a*L/d comes from a restoring divider.
// Depends on lspt_pkg.
module lspt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_stall,
    input  lspt_pkg::lspt_job_t job,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [4:0]         cell_column,
    output logic [4:0]         cell_row,
    output logic [16:0]        path_distance,
    output logic               last_cell
);
    import lspt_pkg::*;

    localparam int FB = COORD_FRAC_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PICK = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]  state_reg;
    lspt_job_t   j_reg;
    logic [4:0]  col_reg, row_reg, ixs, iys;
    logic [5:0]  nv_reg, nh_reg, vi_reg, hi_reg;
    logic [6:0]  n_reg, i_reg;
    logic [16:0] prev_reg;
    logic        pend_v_reg;
    logic [33:0] num_reg;
    logic [16:0] den_reg, quo_reg;
    logic [17:0] rem_reg;
    logic [4:0]  dcnt_reg;
    logic        first_reg;

    logic        ov_reg;
    logic [4:0]  oc_reg, orow_reg;
    logic [16:0] od_reg;
    logic        ol_reg;

    assign ixs = j_reg.xs[FB +: 5];
    assign iys = j_reg.ys[FB +: 5];

    function automatic logic [16:0] loff(input logic [15:0] c, input logic [4:0] idx,
                                         input logic up, input logic [5:0] k);
        logic [22:0] ln;
        ln = up ? (23'(idx) + 23'd1 + 23'(k)) << FB : (23'(idx) - 23'(k)) << FB;
        return up ? 17'(ln - 23'(c)) : 17'(23'(c) - ln);
    endfunction

    logic [16:0] va, ha;
    logic        take_v;
    logic [33:0] lhs, rhs;
    always_comb
    begin
        va = loff(j_reg.xs, ixs, j_reg.xup, vi_reg);
        ha = loff(j_reg.ys, iys, j_reg.yup, hi_reg);
        lhs = 34'(va) * 34'(j_reg.ady);
        rhs = 34'(ha) * 34'(j_reg.adx);
    end

    logic        lt_reg;
    assign take_v = (vi_reg < nv_reg) && ((hi_reg >= nh_reg) || lt_reg);

    logic [33:0] prod;
    assign prod = (take_v ? 34'(va) : 34'(ha)) * 34'(j_reg.len);

    logic [17:0] rsh;
    assign rsh = {rem_reg[16:0], num_reg[33]};

    logic out_free;
    logic fin_go, emit_go;
    assign out_free  = !ov_reg || !out_stall;
    assign fin_go    = (state_reg == S_PICK) && (n_reg == 7'd0 || i_reg == n_reg) && out_free;
    assign emit_go   = (state_reg == S_EMIT) && out_free;
    assign job_stall = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign cell_column   = oc_reg;
    assign cell_row      = orow_reg;
    assign path_distance = od_reg;
    assign last_cell     = ol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            ov_reg <= fin_go || emit_go || (ov_reg && out_stall);
            unique case (state_reg)
                S_IDLE: if (job_valid) state_reg <= S_PICK;
                S_PICK:
                begin
                    if (n_reg == 7'd0 || i_reg == n_reg)
                    begin
                        if (out_free)
                            state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_MUL;
                end
                S_MUL: state_reg <= S_DIV;
                S_DIV: if (dcnt_reg == 5'd0) state_reg <= S_EMIT;
                S_EMIT:
                    if (out_free)
                        state_reg <= S_PICK;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic [5:0] nv_c, nh_c;
    always_comb
    begin
        nv_c = (job.xe[FB +: 5] >= job.xs[FB +: 5]) ?
               6'(job.xe[FB +: 5] - job.xs[FB +: 5]) : 6'(job.xs[FB +: 5] - job.xe[FB +: 5]);
        nh_c = (job.ye[FB +: 5] >= job.ys[FB +: 5]) ?
               6'(job.ye[FB +: 5] - job.ys[FB +: 5]) : 6'(job.ys[FB +: 5] - job.ye[FB +: 5]);
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                j_reg     <= job;
                col_reg   <= job.xs[FB +: 5];
                row_reg   <= job.ys[FB +: 5];
                nv_reg    <= nv_c;
                nh_reg    <= nh_c;
                n_reg     <= 7'(nv_c) + 7'(nh_c);
                vi_reg    <= '0;
                hi_reg    <= '0;
                i_reg     <= '0;
                first_reg <= 1'b1;
                prev_reg  <= '0;
            end
            S_PICK:
            begin
                lt_reg <= lhs <= rhs;
                if (fin_go)
                begin
                    oc_reg   <= col_reg;
                    orow_reg <= row_reg;
                    od_reg   <= j_reg.len;
                    ol_reg   <= 1'b1;
                end
            end
            S_MUL:
            begin
                // Hold the chosen crossing and set up numerator a*L over d.
                pend_v_reg <= take_v;
                den_reg  <= take_v ? {1'b0, j_reg.adx} : {1'b0, j_reg.ady};
                quo_reg  <= '0;
                dcnt_reg <= 5'd16;
                // Quotient fits in 17 bits: preload the top product bits into the remainder.
                rem_reg  <= 18'(prod >> 17);
                num_reg  <= prod << 17;
            end
            S_DIV:
            begin
                if (rsh >= {1'b0, den_reg})
                begin
                    rem_reg <= rsh - {1'b0, den_reg};
                    quo_reg <= {quo_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rsh;
                    quo_reg <= {quo_reg[15:0], 1'b0};
                end
                num_reg  <= num_reg << 1;
                dcnt_reg <= dcnt_reg - 5'd1;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    // Start cell reports zero; a middle cell the midpoint of its crossings.
                    if (first_reg)
                    begin
                        oc_reg   <= col_reg;
                        orow_reg <= row_reg;
                        od_reg   <= '0;
                        ol_reg   <= 1'b0;
                    end
                    else
                    begin
                        oc_reg   <= col_reg;
                        orow_reg <= row_reg;
                        od_reg   <= 17'(({1'b0, prev_reg} + {1'b0, quo_reg}) >> 1);
                        ol_reg   <= 1'b0;
                    end
                    first_reg <= 1'b0;
                    prev_reg  <= quo_reg;
                    i_reg     <= i_reg + 7'd1;
                    if (pend_v_reg)
                    begin
                        vi_reg  <= vi_reg + 6'd1;
                        col_reg <= j_reg.xup ? col_reg + 5'd1 : col_reg - 5'd1;
                    end
                    else
                    begin
                        hi_reg  <= hi_reg + 6'd1;
                        row_reg <= j_reg.yup ? row_reg + 5'd1 : row_reg - 5'd1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/lspt_checker.sv =====
// Port-level checker for line_segment_pixel_trace, bound to the top level.
// No package dependency.
module lspt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        stall,
    input logic [4:0]  cell_column,
    input logic [4:0]  cell_row,
    input logic [16:0] path_distance,
    input logic        last_cell
);
    // A stalled output word stays valid and holds its distance and last flag.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stall |=> out_valid && $stable(path_distance) && $stable(last_cell))
        else $error("stalled word changed");

    // Successive cells of one segment are neighbors: they share a column or a row.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stall && !last_cell ##1 out_valid |->
        ($past(cell_column) == cell_column) || ($past(cell_row) == cell_row))
        else $error("cell jump");

    // The first cell of a segment reports distance zero.
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stall && last_cell ##1 out_valid && !last_cell |->
        path_distance == 17'd0)
        else $error("first cell distance");
endmodule

bind line_segment_pixel_trace lspt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .stall(stall),
    .cell_column(cell_column), .cell_row(cell_row),
    .path_distance(path_distance), .last_cell(last_cell)
);

// ===== dv/testbench.sv =====
// Testbench for line_segment_pixel_trace: drives segments and checks every traced cell word.
// Predicts the cells in order with its own traversal model; depends only on the RTL top level.
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC = 11;
    localparam int GRID = 32;
    localparam int MAX_LINES = 2 * (GRID - 1);
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 3000;

    typedef struct packed {
        logic [4:0]  column;
        logic [4:0]  row;
        logic [16:0] distance;
        logic        last;
    } cell_word_t;

    logic        clk;
    logic        rst_n;
    logic        valid;
    logic        in_stall;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] end_x;
    logic [15:0] end_y;
    logic        out_valid;
    logic        stall;
    logic [4:0]  cell_column;
    logic [4:0]  cell_row;
    logic [16:0] path_distance;
    logic        last_cell;

    cell_word_t expected_cells[$];
    int mismatch_count;
    int cells_checked;
    int segments_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_requests;
    int hold_off_seen;
    int hold_off_left;
    int quiet_cycles;

    line_segment_pixel_trace uut (
        .clk(clk), .rst_n(rst_n),
        .valid(valid), .in_stall(in_stall),
        .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
        .out_valid(out_valid), .stall(stall),
        .cell_column(cell_column), .cell_row(cell_row),
        .path_distance(path_distance), .last_cell(last_cell)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Integer square root, bit by bit.
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Offset from the start coordinate to the k-th grid line crossed.
    function automatic longint unsigned line_gap(longint unsigned c, longint unsigned idx,
                                                 bit up, longint unsigned k);
        if (up)
            return ((idx + 1 + k) << FRAC) - c;
        return c - ((idx - k) << FRAC);
    endfunction

    // Walk the segment through the grid and queue every cell it visits.
    task automatic trace_cells(input logic [15:0] sx, input logic [15:0] sy,
                               input logic [15:0] ex, input logic [15:0] ey);
        longint unsigned xs, ys, xe, ye, ixs, iys, ixe, iye, adx, ady, len;
        longint unsigned nv, nh, n, vi, hi, va, ha, d;
        longint unsigned hit_dist[MAX_LINES + 1];
        bit cross_vert[MAX_LINES + 1];
        bit xup, yup, take_v;
        cell_word_t w;
        int col, row;
        xs = 64'(sx); ys = 64'(sy); xe = 64'(ex); ye = 64'(ey);
        ixs = xs >> FRAC; iys = ys >> FRAC; ixe = xe >> FRAC; iye = ye >> FRAC;
        xup = xe >= xs;
        yup = ye >= ys;
        adx = xup ? xe - xs : xs - xe;
        ady = yup ? ye - ys : ys - ye;
        len = isqrt(adx * adx + ady * ady);
        nv = ixe >= ixs ? ixe - ixs : ixs - ixe;
        nh = iye >= iys ? iye - iys : iys - iye;
        n = nv + nh;
        vi = 0;
        hi = 0;
        for (int i = 0; i < n; i++)
        begin
            va = 0;
            ha = 0;
            if (vi < nv) va = line_gap(xs, ixs, xup, vi);
            if (hi < nh) ha = line_gap(ys, iys, yup, hi);
            if (vi >= nv) take_v = 0;
            else if (hi >= nh) take_v = 1;
            else take_v = va * ady <= ha * adx;   // column change first on a corner
            if (take_v)
            begin
                hit_dist[i] = adx != 0 ? (va * len) / adx : 0;
                vi++;
            end
            else
            begin
                hit_dist[i] = ady != 0 ? (ha * len) / ady : 0;
                hi++;
            end
            cross_vert[i] = take_v;
        end
        col = int'(ixs);
        row = int'(iys);
        if (n == 0)
        begin
            w = '{col[4:0], row[4:0], len[16:0], 1'b1};
            expected_cells.push_back(w);
            return;
        end
        w = '{col[4:0], row[4:0], 17'd0, 1'b0};
        expected_cells.push_back(w);
        for (int i = 0; i < n; i++)
        begin
            if (cross_vert[i]) col = xup ? col + 1 : col - 1;
            else row = yup ? row + 1 : row - 1;
            d = (i + 1 == n) ? len : (hit_dist[i] + hit_dist[i + 1]) >> 1;
            w = '{col[4:0], row[4:0], d[16:0], (i + 1 == n)};
            expected_cells.push_back(w);
        end
    endtask

    // Offer one segment word, with optional idle cycles first; hold until taken.
    task automatic send_segment(input logic [15:0] sx, input logic [15:0] sy,
                                input logic [15:0] ex, input logic [15:0] ey);
        while ($urandom_range(99) < send_idle_pct)
        begin
            valid <= 1'b0;
            @(negedge clk);
        end
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        valid <= 1'b1;
        trace_cells(sx, sy, ex, ey);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        segments_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(negedge clk);
    endtask

    // Random segment: mostly short hops, sometimes across the whole grid.
    task automatic send_random_segment();
        logic [15:0] sx, sy, ex, ey;
        int span;
        sx = 16'($urandom);
        sy = 16'($urandom);
        if ($urandom_range(9) < 2)
        begin
            ex = 16'($urandom);
            ey = 16'($urandom);
        end
        else
        begin
            span = $urandom_range(1, 4) << FRAC;
            ex = 16'($signed({1'b0, sx}) + $signed($urandom_range(0, 2 * span)) - span);
            ey = 16'($signed({1'b0, sy}) + $signed($urandom_range(0, 2 * span)) - span);
        end
        case ($urandom_range(9))
            0: ex = sx;                  // vertical
            1: ey = sy;                  // horizontal
            2: ey = 16'(sy + ex - sx);   // diagonal through corners when aligned
            default: ;
        endcase
        send_segment(sx, sy, ex, ey);
    endtask

    task automatic test_directed();
        send_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000);  // zero length
        send_segment(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_segment(16'h0100, 16'h0200, 16'h0700, 16'h0300);  // single cell
        send_segment(16'h0400, 16'h0400, 16'h0C00, 16'h0400);  // one crossing
        send_segment(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);  // full diagonal, corners
        send_segment(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_segment(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_segment(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_segment(16'h0000, 16'h1234, 16'hFFFF, 16'h1234);  // horizontal full width
        send_segment(16'h5555, 16'hFFFF, 16'h5555, 16'h0000);  // vertical full height
        send_segment(16'h0800, 16'h0800, 16'h1000, 16'h1000);  // exact grid points
        send_segment(16'h0400, 16'h0400, 16'h0C00, 16'h1400);
        send_segment(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        send_segment(16'h0001, 16'hFFFE, 16'hFFFE, 16'h0001);
        wait_drained();
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
            send_random_segment();
    endtask

    // Receiver holds off while long segments keep coming, so the queue backs up.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_requests++;
        repeat (5)
            send_segment(16'h0000, 16'($urandom), 16'hFFFF, 16'($urandom));
        wait_drained();
    endtask

    // Receiver: random stall, long hold-off when asked.
    always @(negedge clk)
    begin
        if (!rst_n)
            stall <= 1'b1;
        else if (hold_off_requests != hold_off_seen)
        begin
            hold_off_seen <= hold_off_requests;
            hold_off_left <= HOLD_OFF_CYCLES - 1;
            stall <= 1'b1;
        end
        else if (hold_off_left > 0)
        begin
            stall <= 1'b1;
            hold_off_left <= hold_off_left - 1;
        end
        else
            stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Check each accepted cell word against the oldest prediction.
    always @(posedge clk)
    begin
        cell_word_t want;
        if (rst_n && out_valid && !stall)
        begin
            cells_checked++;
            if (expected_cells.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected cell word col=%0d row=%0d dist=%0d last=%0b",
                             cell_column, cell_row, path_distance, last_cell);
            end
            else
            begin
                want = expected_cells.pop_front();
                if (want.column !== cell_column || want.row !== cell_row
                    || want.distance !== path_distance || want.last !== last_cell)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("cell mismatch: want col=%0d row=%0d dist=%0d last=%0b,",
                                 want.column, want.row, want.distance, want.last,
                                 " got col=%0d row=%0d dist=%0d last=%0b",
                                 cell_column, cell_row, path_distance, last_cell);
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (valid && !in_stall) || (out_valid && !stall))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        valid = 1'b0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        mismatch_count = 0;
        cells_checked = 0;
        segments_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_requests = 0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(100, 10, 81);
        test_random(100, 81, 10);
        wait_drained();          // sender pauses until every cell is back
        test_backpressure();
        test_random(100, 0, 0);
        wait_drained();
        repeat (100)
            @(negedge clk);

        $display("Traced %0d segments (directed corners, axis-aligned, random, back-pressure)",
                 segments_sent);
        $display("Checked %0d cell words, %0d mismatches", cells_checked, mismatch_count);
        if (mismatch_count == 0 && expected_cells.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
